@@ rtl/lsbse_pkg.sv @@
// Shared constants, register codes and types for the LSB stego embed/extract unit.
package lsbse_pkg;

   localparam int HEADER_BITS   = 64;
   localparam int POSITION_BITS = 32;

   localparam int WORD_W   = 32;
   localparam int STRIDE_W = 16;
   localparam int SLOT_W   = 36;
   localparam int BYTE_W   = 8;

   // Header bits are placed inside whole bytes, so the shift register spans full bytes.
   localparam int HDR_SPAN = ((HEADER_BITS + 7) / 8) * 8;
   localparam int HS_W     = (HDR_SPAN > WORD_W) ? HDR_SPAN : WORD_W;
   localparam int HS_IDX_W = $clog2(HS_W);

   localparam int CMP_W  = (POSITION_BITS > WORD_W) ? POSITION_BITS : WORD_W;
   localparam int PROD_W = SLOT_W + STRIDE_W;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECRET_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_BYTES   = 3'd4;

   localparam logic MODE_EMBED   = 1'b0;
   localparam logic MODE_EXTRACT = 1'b1;

   typedef struct packed {
      logic                mode;
      logic [WORD_W-1:0]   start_offset;
      logic [STRIDE_W-1:0] stride;
      logic [WORD_W-1:0]   secret_length;
      logic [WORD_W-1:0]   image_bytes;
   } lsbse_cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] carrier_out;
      logic              secret_taken;
      logic [BYTE_W-1:0] recovered_byte;
      logic              recovered_valid;
      logic              payload_done;
      logic              too_long;
   } lsbse_result_type;

endpackage

@@ rtl/lsbse_slot_gen.sv @@
// Carrier position counter and stride countdown that flag slot bytes.
module lsbse_slot_gen (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic                    restart,
   input  lsbse_pkg::lsbse_cfg_type cfg,
   output logic                    slot
);
   import lsbse_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MASK = '1;

   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_cur;
   logic [STRIDE_W-1:0]      cd_ff, cd_in, cd_cur, st_m1;
   logic [CMP_W-1:0]         cur_w, so_w, mask_w;

   always_comb begin
      pos_cur = restart ? '0 : pos_ff;
      cd_cur  = restart ? '0 : cd_ff;
      st_m1   = (cfg.stride == '0) ? '0 : cfg.stride - STRIDE_W'(1);
      cur_w   = CMP_W'(pos_cur);
      so_w    = CMP_W'(cfg.start_offset);
      mask_w  = CMP_W'(POS_MASK);

      slot  = 1'b0;
      cd_in = cd_cur;
      if (cur_w == so_w && so_w < mask_w) begin
         slot  = 1'b1;
         cd_in = st_m1;
      end else if (cur_w > so_w) begin
         if (cd_cur == '0) begin
            slot  = 1'b1;
            cd_in = st_m1;
         end else begin
            cd_in = cd_cur - STRIDE_W'(1);
         end
      end

      // The position stops once it has passed the first slot.
      if (cur_w <= so_w && pos_cur < POS_MASK) begin
         pos_in = pos_cur + POSITION_BITS'(1);
      end else begin
         pos_in = pos_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cd_ff  <= '0;
      end else if (fire) begin
         pos_ff <= pos_in;
         cd_ff  <= cd_in;
      end
   end

endmodule

@@ rtl/lsbse_capacity.sv @@
// Capacity check: position of the last embed slot against the carrier size.
module lsbse_capacity (
   input  logic                    clock,
   input  lsbse_pkg::lsbse_cfg_type cfg,
   output logic                    oversize
);
   import lsbse_pkg::*;

   logic [SLOT_W-1:0]   span_m1;
   logic [STRIDE_W-1:0] st;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PROD_W:0]     last_slot;

   always_comb begin
      span_m1 = SLOT_W'(HEADER_BITS - 1) + SLOT_W'({cfg.secret_length, 3'b000});
      st      = (cfg.stride == '0) ? STRIDE_W'(1) : cfg.stride;
      prod_in = PROD_W'(span_m1) * PROD_W'(st);
   end

   // The user changes configuration only while idle; the block does not enforce it.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      last_slot = {1'b0, prod_ff} + (PROD_W + 1)'(cfg.start_offset);
      oversize  = (cfg.mode == MODE_EMBED) && (last_slot >= (PROD_W + 1)'(cfg.image_bytes));
   end

endmodule

@@ rtl/lsbse_codec.sv @@
// Slot bit codec: header and payload embedding or extraction for one carrier byte.
module lsbse_codec (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic                        restart,
   input  logic                        slot,
   input  logic                        oversize,
   input  lsbse_pkg::lsbse_cfg_type     cfg,
   input  logic [lsbse_pkg::BYTE_W-1:0] carrier,
   input  logic [lsbse_pkg::BYTE_W-1:0] secret,
   output lsbse_pkg::lsbse_result_type  result
);
   import lsbse_pkg::*;

   logic [SLOT_W-1:0]   k_ff, k_in, k_cur, j, need_cur, need_next;
   logic [HS_W-1:0]     hs_ff, hs_in, hs_cur, len_ext;
   logic [BYTE_W-1:0]   asm_ff, asm_in, asm_cur, asm_shift;
   logic [WORD_W-1:0]   len_ff, len_in, len_cur, len_sel_cur, len_sel_next;
   logic [HS_IDX_W-1:0] hpos;
   logic [2:0]          bit_idx;
   logic                done_cur, done_next, active, lsb, emb_bit;

   always_comb begin
      k_cur   = restart ? '0 : k_ff;
      hs_cur  = restart ? '0 : hs_ff;
      asm_cur = restart ? '0 : asm_ff;
      len_cur = restart ? '0 : len_ff;

      len_sel_cur = (cfg.mode == MODE_EXTRACT) ? len_cur : cfg.secret_length;
      need_cur    = SLOT_W'(HEADER_BITS) + SLOT_W'({len_sel_cur, 3'b000});
      done_cur    = (k_cur >= need_cur);
      active      = slot && !oversize && !done_cur;

      lsb       = carrier[0];
      len_ext   = HS_W'(cfg.secret_length);
      // Header bits go MSB first within each byte: invert the bit number inside the byte.
      hpos      = {k_cur[HS_IDX_W-1:3], ~k_cur[2:0]};
      j         = k_cur - SLOT_W'(HEADER_BITS);
      bit_idx   = ~j[2:0];
      asm_shift = {asm_cur[BYTE_W-2:0], lsb};
      emb_bit   = 1'b0;

      k_in   = k_cur;
      hs_in  = hs_cur;
      asm_in = asm_cur;
      len_in = len_cur;

      result                 = '0;
      result.carrier_out     = carrier;

      if (active) begin
         k_in = k_cur + SLOT_W'(1);
         if (k_cur < SLOT_W'(HEADER_BITS)) begin
            if (cfg.mode == MODE_EMBED) begin
               emb_bit            = len_ext[hpos];
               result.carrier_out = {carrier[BYTE_W-1:1], emb_bit};
            end else begin
               hs_in[hpos] = hs_cur[hpos] | lsb;
               if (k_cur == SLOT_W'(HEADER_BITS - 1)) begin
                  len_in = hs_in[WORD_W-1:0];
               end
            end
         end else begin
            if (cfg.mode == MODE_EMBED) begin
               emb_bit             = secret[bit_idx];
               result.carrier_out  = {carrier[BYTE_W-1:1], emb_bit};
               result.secret_taken = (j[2:0] == 3'd7);
            end else begin
               asm_in = asm_shift;
               if (j[2:0] == 3'd7) begin
                  result.recovered_byte  = asm_shift;
                  result.recovered_valid = 1'b1;
                  asm_in                 = '0;
               end
            end
         end
      end

      len_sel_next        = (cfg.mode == MODE_EXTRACT) ? len_in : cfg.secret_length;
      need_next           = SLOT_W'(HEADER_BITS) + SLOT_W'({len_sel_next, 3'b000});
      done_next           = (k_in >= need_next);
      result.payload_done = !oversize && done_next;
      result.too_long     = oversize;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= '0;
         hs_ff  <= '0;
         asm_ff <= '0;
         len_ff <= '0;
      end else if (fire) begin
         k_ff   <= k_in;
         hs_ff  <= hs_in;
         asm_ff <= asm_in;
         len_ff <= len_in;
      end
   end

endmodule

@@ rtl/lsb_stego_embed_extract_unit.sv @@
// Top level of the LSB stego embed/extract unit: registers, beat pipeline and datapath.
//
//   channel | dir | width   | contents
//   req_    | in  | 16 + 1  | carrier and secret bytes, image start flag
//   rsp_    | out | 16 + 4  | output carrier and recovered bytes, status flags
//   csr_    | in  | 3 + 32  | register write: index and data
//
// One beat per cycle sustained while rsp_ is ready; an accepted beat is held in the input
// register and its result is captured in the result register, which drives rsp_.
// The slot and header state updates when a beat fires.
// Reset is synchronous and restores the configuration and control registers to their defaults.
// A stalled result holds the result register; one more beat can still enter an empty
// input register, after which req_tready stays low until the result is taken.
// A register write updates the configuration register, used by a beat when it fires.
module lsb_stego_embed_extract_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,  // carrier_byte, secret_byte
   input  logic                             req_tuser,  // image_start
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,  // carrier_out, recovered_byte
   output logic [3:0]                       rsp_tuser,  // secret_taken, recovered_valid,
                                                        // payload_done, too_long
   input  logic                             csr_wr_en,
   input  logic [lsbse_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lsbse_pkg::WORD_W-1:0]     csr_wdata
);
   import lsbse_pkg::*;

   lsbse_cfg_type    cfg_ff;
   lsbse_result_type result;
   lsbse_result_type rsp_ff;

   logic              in_valid_ff, rsp_valid_ff, fire, slot, oversize;
   logic [BYTE_W-1:0] carrier_ff, secret_ff;
   logic              start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= MODE_EMBED;
         cfg_ff.start_offset  <= '0;
         cfg_ff.stride        <= STRIDE_W'(1);
         cfg_ff.secret_length <= '0;
         cfg_ff.image_bytes   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:          cfg_ff.mode          <= csr_wdata[0];
            CSR_START_OFFSET:  cfg_ff.start_offset  <= csr_wdata;
            CSR_STRIDE:        cfg_ff.stride        <= csr_wdata[STRIDE_W-1:0];
            CSR_SECRET_LENGTH: cfg_ff.secret_length <= csr_wdata;
            CSR_IMAGE_BYTES:   cfg_ff.image_bytes   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         carrier_ff <= req_tdata[7:0];
         secret_ff  <= req_tdata[15:8];
         start_ff   <= req_tuser;
      end
   end

   lsbse_slot_gen u_slot_gen (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .restart (start_ff),
      .cfg     (cfg_ff),
      .slot    (slot)
   );

   lsbse_capacity u_capacity (
      .clock    (clock),
      .cfg      (cfg_ff),
      .oversize (oversize)
   );

   lsbse_codec u_codec (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .restart  (start_ff),
      .slot     (slot),
      .oversize (oversize),
      .cfg      (cfg_ff),
      .carrier  (carrier_ff),
      .secret   (secret_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.recovered_byte, rsp_ff.carrier_out};
   assign rsp_tuser  = {rsp_ff.too_long, rsp_ff.payload_done,
                        rsp_ff.recovered_valid, rsp_ff.secret_taken};

endmodule
